[sv/wtpm_pkg.sv]
// shared types, constants and command structs for the wavetable oscillator voice
// used by the controller, the datapath and the top level
package wtpm_pkg;

    // table and phase geometry
    localparam int TABLE_DEPTH = 8192;
    localparam int PHASE_BITS  = 24;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);

    // register and field widths
    localparam int STEP_W  = 24;
    localparam int GAIN_W  = 17;
    localparam int LEN_W   = 14;
    localparam int SMP_W   = 16;
    localparam int MIX_W   = 20;
    localparam int CFG_W   = 24;
    localparam int CFG_A_W = 3;

    // shared multiplier geometry
    localparam int S_W  = SMP_W + GAIN_W;
    localparam int MA_W = (PHASE_BITS + 1 > S_W) ? PHASE_BITS + 1 : S_W;
    localparam int MB_W = (LEN_W + 1 > GAIN_W + 1) ? LEN_W + 1 : GAIN_W + 1;
    localparam int P_W  = MA_W + MB_W;

    // rounding of a Q1.47 part to Q1.15
    localparam int RND_SHIFT = 32;
    localparam int RND_W     = P_W + 1 - RND_SHIFT;

    localparam logic [GAIN_W-1:0] UNITY = GAIN_W'(65536);

    // register indexes
    typedef enum logic [CFG_A_W-1:0] {
        CFG_PHASE_STEP    = 3'd0,
        CFG_VOLUME        = 3'd1,
        CFG_PAN           = 3'd2,
        CFG_TABLE_LENGTH  = 3'd3,
        CFG_SILENCE_LEVEL = 3'd4
    } cfg_idx_t;

    // input item modes
    typedef enum logic {
        MODE_WRITE  = 1'b0,
        MODE_SAMPLE = 1'b1
    } mode_t;

    typedef struct packed {
        logic                    mode;
        logic [12:0]             table_index;
        logic signed [SMP_W-1:0] table_value;
        logic signed [MIX_W-1:0] mix_left;
        logic signed [MIX_W-1:0] mix_right;
    } in_item_t;

    typedef struct packed {
        logic signed [MIX_W-1:0] out_left;
        logic signed [MIX_W-1:0] out_right;
    } out_item_t;

    // operand selection of the shared multiplier
    typedef enum logic [1:0] {
        MUL_INDEX = 2'd0,
        MUL_SCALE = 2'd1,
        MUL_LEFT  = 2'd2,
        MUL_RIGHT = 2'd3
    } mul_sel_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PHASE,
        ST_INDEX,
        ST_READ,
        ST_SCALE,
        ST_LEFT,
        ST_RIGHT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic     capture;
        logic     table_wr;
        logic     phase_adv;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     rd_en;
        logic     latch_s;
        logic     latch_left;
        logic     load_out;
        logic     bypass;
    } cmd_t;

    typedef struct packed {
        logic audible;
    } sts_t;

endpackage

[sv/wtpm_ctrl.sv]
// sequencing state machine of the oscillator voice and the output beat valid
// depends on wtpm_pkg for state, command and status types
module wtpm_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic          in_mode,
    output logic          m_valid,
    input  logic          m_ready,
    input  wtpm_pkg::sts_t sts,
    output wtpm_pkg::cmd_t cmd
);
    import wtpm_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;
    logic   out_free;

    assign accept   = s_valid && (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || m_ready;

    // state and output valid registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && (mode_t'(in_mode) == MODE_SAMPLE)) begin
                    state_next = sts.audible ? ST_PHASE : ST_EMIT;
                end
            end
            ST_PHASE: state_next = ST_INDEX;
            ST_INDEX: state_next = ST_READ;
            ST_READ:  state_next = ST_SCALE;
            ST_SCALE: state_next = ST_LEFT;
            ST_LEFT:  state_next = ST_RIGHT;
            ST_RIGHT: state_next = ST_EMIT;
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // commands to the datapath
    always_comb begin
        cmd            = '0;
        cmd.mul_sel    = MUL_INDEX;
        out_valid_next = out_valid_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                cmd.capture  = accept;
                cmd.table_wr = accept && (mode_t'(in_mode) == MODE_WRITE);
            end
            ST_PHASE: cmd.phase_adv = 1'b1;
            ST_INDEX: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_INDEX;
            end
            ST_READ: cmd.rd_en = 1'b1;
            ST_SCALE: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_SCALE;
            end
            ST_LEFT: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_LEFT;
                cmd.latch_s = 1'b1;
            end
            ST_RIGHT: begin
                cmd.mul_en     = 1'b1;
                cmd.mul_sel    = MUL_RIGHT;
                cmd.latch_left = 1'b1;
            end
            ST_EMIT: begin
                cmd.bypass = !sts.audible;
                if (out_free) begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_valid_reg;

endmodule

[sv/wtpm_datapath.sv]
// registers, phase accumulator, waveform table, shared multiplier and mixing
// depends on wtpm_pkg for widths, item structs and the command struct
module wtpm_datapath (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [wtpm_pkg::CFG_A_W-1:0] cfg_index,
    input  logic [wtpm_pkg::CFG_W-1:0]   cfg_wdata,
    input  wtpm_pkg::in_item_t          s_data,
    output wtpm_pkg::out_item_t         m_data,
    input  wtpm_pkg::cmd_t              cmd,
    output wtpm_pkg::sts_t              sts
);
    import wtpm_pkg::*;

    // configuration registers
    logic [STEP_W-1:0] phase_step_reg;
    logic [GAIN_W-1:0] volume_reg;
    logic [GAIN_W-1:0] pan_reg;
    logic [LEN_W-1:0]  table_length_reg;
    logic [GAIN_W-1:0] silence_level_reg;

    // voice state
    logic [PHASE_BITS-1:0] phase_reg;
    logic [SMP_W-1:0]      mem [TABLE_DEPTH];
    logic signed [SMP_W-1:0] rd_data_reg;

    // working registers
    logic signed [MIX_W-1:0] mix_l_reg, mix_r_reg;
    logic signed [P_W-1:0]   prod_reg;
    logic signed [S_W-1:0]   s_reg;
    logic signed [RND_W-1:0] left_reg;
    out_item_t               out_reg;

    logic [LEN_W-1:0]  len_sat;
    logic [GAIN_W-1:0] vol_sat;
    logic [GAIN_W-1:0] pan_sat;
    logic [LEN_W-1:0]  idx_raw;
    logic [IDX_W-1:0]  rd_addr;
    logic signed [MA_W-1:0] mul_a;
    logic signed [MB_W-1:0] mul_b;
    logic signed [P_W-1:0]  prod_next;
    logic signed [RND_W-1:0] right_part;
    out_item_t out_next;

    // round a Q1.47 part to Q1.15, ties toward plus infinity
    function automatic logic signed [RND_W-1:0] round_part(input logic signed [P_W-1:0] x);
        logic signed [P_W:0] biased;
        biased = (P_W+1)'(x) + (P_W+1)'(64'd1 << (RND_SHIFT - 1));
        return biased[P_W:RND_SHIFT];
    endfunction

    // add a part to a mix sample and clamp to the mix range
    function automatic logic signed [MIX_W-1:0] mix_sat(input logic signed [MIX_W-1:0] mix,
                                                       input logic signed [RND_W-1:0] part);
        logic signed [MIX_W+1:0] sum;
        logic signed [MIX_W+1:0] max_v;
        logic signed [MIX_W+1:0] min_v;
        sum   = (MIX_W+2)'(mix) + (MIX_W+2)'(part);
        max_v = (MIX_W+2)'((64'd1 << (MIX_W - 1)) - 64'd1);
        min_v = -max_v - (MIX_W+2)'(1);
        if (sum > max_v) begin
            return max_v[MIX_W-1:0];
        end else if (sum < min_v) begin
            return min_v[MIX_W-1:0];
        end else begin
            return sum[MIX_W-1:0];
        end
    endfunction

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_step_reg    <= '0;
            volume_reg        <= UNITY;
            pan_reg           <= GAIN_W'(32768);
            table_length_reg  <= LEN_W'(TABLE_DEPTH);
            silence_level_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_index))
                CFG_PHASE_STEP:    phase_step_reg    <= cfg_wdata[STEP_W-1:0];
                CFG_VOLUME:        volume_reg        <= cfg_wdata[GAIN_W-1:0];
                CFG_PAN:           pan_reg           <= cfg_wdata[GAIN_W-1:0];
                CFG_TABLE_LENGTH:  table_length_reg  <= cfg_wdata[LEN_W-1:0];
                CFG_SILENCE_LEVEL: silence_level_reg <= cfg_wdata[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // phase accumulator wraps modulo one waveform period (2^PHASE_BITS)
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
        end else if (cmd.phase_adv) begin
            phase_reg <= phase_reg + PHASE_BITS'(phase_step_reg);
        end
    end

    // saturated operands
    assign len_sat = (32'(table_length_reg) > TABLE_DEPTH) ? LEN_W'(TABLE_DEPTH)
                                                           : table_length_reg;
    assign vol_sat = (volume_reg > UNITY) ? UNITY : volume_reg;
    assign pan_sat = (pan_reg > UNITY) ? UNITY : pan_reg;

    assign sts.audible = (volume_reg > silence_level_reg);

    // table index from the top bits of phase times length
    assign idx_raw = prod_reg[PHASE_BITS +: LEN_W];
    assign rd_addr = (32'(idx_raw) >= TABLE_DEPTH) ? '0 : idx_raw[IDX_W-1:0];

    // waveform table, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.table_wr && (32'(s_data.table_index) < TABLE_DEPTH)) begin
            mem[s_data.table_index[IDX_W-1:0]] <= s_data.table_value;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_sel)
            MUL_INDEX: begin
                mul_a = signed'(MA_W'(phase_reg));
                mul_b = signed'(MB_W'(len_sat));
            end
            MUL_SCALE: begin
                mul_a = MA_W'(rd_data_reg);
                mul_b = signed'(MB_W'(vol_sat));
            end
            MUL_LEFT: begin
                mul_a = MA_W'(signed'(prod_reg[S_W-1:0]));
                mul_b = signed'(MB_W'(UNITY - pan_sat));
            end
            MUL_RIGHT: begin
                mul_a = MA_W'(s_reg);
                mul_b = signed'(MB_W'(pan_sat));
            end
            default: ;
        endcase
    end

    assign prod_next = P_W'(mul_a * mul_b);

    // mix input, product, scaled sample and left part registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            mix_l_reg <= s_data.mix_left;
            mix_r_reg <= s_data.mix_right;
        end
        if (cmd.mul_en) begin
            prod_reg <= prod_next;
        end
        if (cmd.latch_s) begin
            s_reg <= prod_reg[S_W-1:0];
        end
        if (cmd.latch_left) begin
            left_reg <= round_part(prod_reg);
        end
    end

    // final mix or pass-through
    assign right_part = round_part(prod_reg);

    always_comb begin
        if (cmd.bypass) begin
            out_next.out_left  = mix_l_reg;
            out_next.out_right = mix_r_reg;
        end else begin
            out_next.out_left  = mix_sat(mix_l_reg, left_reg);
            out_next.out_right = mix_sat(mix_r_reg, right_part);
        end
    end

    // output beat register
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_reg <= out_next;
        end
    end

    assign m_data = out_reg;

endmodule

[sv/wavetable_oscillator_pan_mix_core.sv]
// Wavetable oscillator voice with stereo pan: a beat with mode 0 writes one
// table entry in the cycle it is accepted and gives no result; a mode 1 beat
// gives one stereo result. An audible sample goes from accept to the result
// register through phase advance, index multiply, table read, then three passes
// through one shared multiplier and a final mix and clamp; a silent one passes
// its mix through. The next beat is accepted in the cycle after the result is
// loaded into the output register; a waiting result does not hold up that
// accept, but a later result waits until the output register is free. The
// waveform table is a single-port-write, registered-read memory with no clearing
// pass: entries must be written before a sample reads them. The user must write
// registers via cfg_we, cfg_index and cfg_wdata only while idle; not enforced.
// depends on wtpm_pkg, wtpm_ctrl and wtpm_datapath
module wavetable_oscillator_pan_mix_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [wtpm_pkg::CFG_A_W-1:0] cfg_index,
    input  logic [wtpm_pkg::CFG_W-1:0]   cfg_wdata,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  wtpm_pkg::in_item_t           s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output wtpm_pkg::out_item_t          m_data
);
    import wtpm_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // sequencer
    wtpm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .in_mode (s_data.mode),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // datapath
    wtpm_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .m_data    (m_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
